@@ hdl/hcd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcd_pkg
// Shared types and constants for the heightmap cluster decimator.
// ----------------------------------------------------------------------------
package hcd_pkg;

	localparam int unsigned MAX_CHUNK_DEF = 256;

	localparam int unsigned REG_W    = 16;  // config data port width
	localparam int unsigned CHUNK_W  = 9;
	localparam int unsigned CLUS_W   = 9;
	localparam int unsigned QUAD_W   = 16;
	localparam int unsigned HEIGHT_W = 24;
	localparam int unsigned SUM_W    = 40;
	localparam int unsigned IDX_W    = 16;
	localparam int unsigned POS_W    = 26;
	localparam int unsigned TEX_W    = 16;

	// iterative divider: dividend and divisor widths
	localparam int unsigned DIV_NW = 42;
	localparam int unsigned DIV_DW = 18;

	localparam logic [CHUNK_W-1:0] CHUNK_RST = 9'd64;
	localparam logic [CLUS_W-1:0]  CLUS_RST  = 9'd4;
	localparam logic [QUAD_W-1:0]  QUAD_RST  = 16'd100;

	typedef enum logic [1:0] {
		REG_CHUNK   = 2'd0,
		REG_CLUSTER = 2'd1,
		REG_QUAD    = 2'd2,
		REG_NONE    = 2'd3
	} hcd_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_N,
		ST_DIV_X,
		ST_DIV_Y,
		ST_READ,
		ST_WRITE,
		ST_DIV_M,
		ST_DIV_U,
		ST_DIV_V,
		ST_EMIT,
		ST_STEP
	} hcd_state_t;

endpackage

@@ hdl/heightmap_cluster_decimation.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightmap_cluster_decimation
// Sums heightmap samples per square cluster in a line store and emits one
// vertex with centroid, mean height, texture and triangle indices per cluster.
// ----------------------------------------------------------------------------
// Latency/throughput: one sample at a time, taken only in idle. A sample outside the
// covered grid runs the divisions for grid size, cluster column and cluster row; one
// inside it that closes no cluster also updates the line store, one that closes a
// cluster divides for mean height, u and v too and waits on out_ready; with cluster size
// zero no division runs. The shared bit-serial divider yields one quotient bit per cycle.
// Reset: counters and vertex index clear, registers take 64/4/100; line store not cleared.
module heightmap_cluster_decimation #(
	parameter int unsigned MAX_CHUNK = hcd_pkg::MAX_CHUNK_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_en,
	input  logic [1:0]                          cfg_index,
	input  logic [hcd_pkg::REG_W-1:0]           cfg_data,
	// samples
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [hcd_pkg::HEIGHT_W-1:0] height,
	input  logic                                first_sample,
	// vertices
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [hcd_pkg::IDX_W-1:0]           vertex_index,
	output logic [hcd_pkg::POS_W-1:0]           pos_x_twice,
	output logic [hcd_pkg::POS_W-1:0]           pos_y_twice,
	output logic signed [hcd_pkg::HEIGHT_W-1:0] height_mean,
	output logic [hcd_pkg::TEX_W-1:0]           tex_u,
	output logic [hcd_pkg::TEX_W-1:0]           tex_v,
	output logic                                tri_valid,
	output logic [hcd_pkg::IDX_W-1:0]           idx_below,
	output logic [hcd_pkg::IDX_W-1:0]           idx_right,
	output logic [hcd_pkg::IDX_W-1:0]           idx_diagonal,
	output logic                                last_vertex
);

	localparam int unsigned CW  = $clog2(MAX_CHUNK + 1);
	localparam int unsigned AW  = $clog2(MAX_CHUNK);
	localparam int unsigned NW  = hcd_pkg::DIV_NW;
	localparam int unsigned DW  = hcd_pkg::DIV_DW;
	localparam int unsigned KW  = $clog2(NW + 1);
	localparam int unsigned SW  = hcd_pkg::SUM_W;
	localparam int unsigned HW  = hcd_pkg::HEIGHT_W;
	localparam int unsigned PW  = CW + hcd_pkg::CLUS_W;
	localparam int unsigned XW  = PW + 1;
	localparam int unsigned MW  = hcd_pkg::QUAD_W + XW;
	localparam int unsigned QW  = 2 * hcd_pkg::CLUS_W;

	// registers
	logic [hcd_pkg::CHUNK_W-1:0] chunk_q;
	logic [hcd_pkg::CLUS_W-1:0]  cs_q;
	logic [hcd_pkg::QUAD_W-1:0]  quad_q;

	// control
	hcd_pkg::hcd_state_t state_q, state_d;
	logic [CW-1:0]    col_q, row_q, col_w_q, row_w_q;
	logic [hcd_pkg::IDX_W-1:0] nv_q;
	logic signed [HW-1:0] h_q;

	// per-sample working values
	logic [CW-1:0]    n_q, cx_q, cy_q;
	logic [hcd_pkg::CLUS_W-1:0] dx_q, dy_q;
	logic [PW-1:0]    cxcs_q, cycs_q;
	logic             neg_q;
	logic [HW-1:0]    mean_q;
	logic [hcd_pkg::TEX_W-1:0] u_q;
	logic [hcd_pkg::POS_W-1:0] px_q, py_q;

	// line store
	logic [SW-1:0] sums_mem [MAX_CHUNK];
	logic [SW-1:0] rd_q;
	logic          wr_en;
	logic [SW-1:0] wr_sum;

	// divider
	logic [NW-1:0] dq_q;
	logic [DW:0]   dr_q;
	logic [DW-1:0] dd_q;
	logic [KW-1:0] dcnt_q;
	logic          div_load;
	logic [NW-1:0] div_num;
	logic [DW-1:0] div_den;
	logic [DW:0]   rem_sh, rem_sub;
	logic          div_done;

	// output register
	logic out_load;

	logic [CW-1:0]  chunk_eff;
	logic [SW-1:0]  h_ext;
	logic [QW-1:0]  dsq;
	logic [SW-1:0]  mag;
	logic [XW-1:0]  xterm, yterm;
	logic [MW-1:0]  pmul;
	logic           cluster_end;
	logic           in_grid;

	assign chunk_eff = (32'(chunk_q) > MAX_CHUNK) ? CW'(MAX_CHUNK) : CW'(chunk_q);
	assign h_ext     = SW'(h_q);
	assign dsq       = QW'(cs_q) * QW'(cs_q);
	assign mag       = wr_sum[SW-1] ? (~wr_sum + SW'(1)) : wr_sum;
	assign xterm     = {cxcs_q, 1'b0} + XW'(cs_q) - XW'(1);
	assign yterm     = {cycs_q, 1'b0} + XW'(cs_q) - XW'(1);
	assign pmul      = MW'(quad_q) * MW'(state_q == hcd_pkg::ST_DIV_U ? xterm : yterm);
	assign in_grid   = (cx_q < n_q) && (cy_q < n_q);
	assign cluster_end = (dx_q == cs_q - 1'b1) && (dy_q == cs_q - 1'b1);
	assign wr_sum    = (dx_q == '0 && dy_q == '0) ? h_ext : rd_q + h_ext;

	assign rem_sh   = {dr_q[DW-1:0], dq_q[NW-1]};
	assign rem_sub  = rem_sh - {1'b0, dd_q};
	assign div_done = (dcnt_q == '0);

	assign in_ready = (state_q == hcd_pkg::ST_IDLE);
	assign out_load = (state_q == hcd_pkg::ST_EMIT) && (!out_valid || out_ready);

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q <= hcd_pkg::CHUNK_RST;
			cs_q    <= hcd_pkg::CLUS_RST;
			quad_q  <= hcd_pkg::QUAD_RST;
		end else if (cfg_en) begin
			case (hcd_pkg::hcd_reg_t'(cfg_index))
				hcd_pkg::REG_CHUNK:   chunk_q <= cfg_data[hcd_pkg::CHUNK_W-1:0];
				hcd_pkg::REG_CLUSTER: cs_q    <= cfg_data[hcd_pkg::CLUS_W-1:0];
				hcd_pkg::REG_QUAD:    quad_q  <= cfg_data[hcd_pkg::QUAD_W-1:0];
				default: ;
			endcase
		end
	end

	// next state and divider launch
	always_comb begin
		state_d  = state_q;
		div_load = 1'b0;
		div_num  = '0;
		div_den  = '0;
		wr_en    = 1'b0;
		case (state_q)
			hcd_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (cs_q == '0) begin
						state_d = hcd_pkg::ST_STEP;
					end else begin
						div_load = 1'b1;
						div_num  = NW'(chunk_eff);
						div_den  = DW'(cs_q);
						state_d  = hcd_pkg::ST_DIV_N;
					end
				end
			end
			hcd_pkg::ST_DIV_N: begin
				if (div_done) begin
					div_load = 1'b1;
					div_num  = NW'(col_w_q);
					div_den  = DW'(cs_q);
					state_d  = hcd_pkg::ST_DIV_X;
				end
			end
			hcd_pkg::ST_DIV_X: begin
				if (div_done) begin
					div_load = 1'b1;
					div_num  = NW'(row_w_q);
					div_den  = DW'(cs_q);
					state_d  = hcd_pkg::ST_DIV_Y;
				end
			end
			hcd_pkg::ST_DIV_Y: begin
				if (div_done) state_d = hcd_pkg::ST_READ;
			end
			hcd_pkg::ST_READ: begin
				state_d = in_grid ? hcd_pkg::ST_WRITE : hcd_pkg::ST_STEP;
			end
			hcd_pkg::ST_WRITE: begin
				wr_en = 1'b1;
				if (cluster_end) begin
					// cluster closes only when cs <= chunk, so cs^2 needs at most 17 bits
					div_load = 1'b1;
					div_num  = {(NW-SW-1)'(0), mag, 1'b0} + NW'(dsq);
					div_den  = {dsq[DW-2:0], 1'b0};
					state_d  = hcd_pkg::ST_DIV_M;
				end else begin
					state_d = hcd_pkg::ST_STEP;
				end
			end
			hcd_pkg::ST_DIV_M: begin
				if (div_done) begin
					div_load = 1'b1;
					div_num  = NW'({cx_q, 16'd0});
					div_den  = DW'(n_q);
					state_d  = hcd_pkg::ST_DIV_U;
				end
			end
			hcd_pkg::ST_DIV_U: begin
				if (div_done) begin
					div_load = 1'b1;
					div_num  = NW'({cy_q, 16'd0});
					div_den  = DW'(n_q);
					state_d  = hcd_pkg::ST_DIV_V;
				end
			end
			hcd_pkg::ST_DIV_V: begin
				if (div_done) state_d = hcd_pkg::ST_EMIT;
			end
			hcd_pkg::ST_EMIT: begin
				if (out_load) state_d = hcd_pkg::ST_STEP;
			end
			hcd_pkg::ST_STEP: begin
				state_d = hcd_pkg::ST_IDLE;
			end
			default: state_d = hcd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= hcd_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			nv_q  <= '0;
		end else begin
			if (state_q == hcd_pkg::ST_IDLE && in_valid && first_sample) nv_q <= '0;
			if (out_load) nv_q <= nv_q + 1'b1;
			if (state_q == hcd_pkg::ST_STEP) begin
				if (col_w_q >= chunk_eff) begin
					col_q <= '0;
					if (row_w_q >= chunk_eff) begin
						row_q <= '0;
						nv_q  <= '0;
					end else begin
						row_q <= row_w_q + 1'b1;
					end
				end else begin
					col_q <= col_w_q + 1'b1;
					row_q <= row_w_q;
				end
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (state_q == hcd_pkg::ST_IDLE && in_valid) begin
			h_q     <= height;
			col_w_q <= first_sample ? '0 : col_q;
			row_w_q <= first_sample ? '0 : row_q;
		end
		if (div_done) begin
			case (state_q)
				hcd_pkg::ST_DIV_N: n_q <= dq_q[CW-1:0];
				hcd_pkg::ST_DIV_X: begin
					cx_q <= dq_q[CW-1:0];
					dx_q <= dr_q[hcd_pkg::CLUS_W-1:0];
				end
				hcd_pkg::ST_DIV_Y: begin
					cy_q <= dq_q[CW-1:0];
					dy_q <= dr_q[hcd_pkg::CLUS_W-1:0];
				end
				hcd_pkg::ST_DIV_M: mean_q <= neg_q ? (~dq_q[HW-1:0] + HW'(1)) : dq_q[HW-1:0];
				hcd_pkg::ST_DIV_U: u_q <= dq_q[hcd_pkg::TEX_W-1:0];
				default: ;
			endcase
		end
		if (state_q == hcd_pkg::ST_READ) begin
			cxcs_q <= PW'(cx_q) * PW'(cs_q);
			cycs_q <= PW'(cy_q) * PW'(cs_q);
		end
		if (state_q == hcd_pkg::ST_WRITE) begin
			neg_q <= wr_sum[SW-1];
		end
		if (state_q == hcd_pkg::ST_DIV_U) px_q <= pmul[hcd_pkg::POS_W-1:0];
		if (state_q == hcd_pkg::ST_DIV_V) py_q <= pmul[hcd_pkg::POS_W-1:0];
	end

	// line store, registered read
	always_ff @(posedge clk) begin
		if (wr_en) sums_mem[cx_q[AW-1:0]] <= wr_sum;
		rd_q <= sums_mem[cx_q[AW-1:0]];
	end

	// restoring divider, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (div_load) begin
			dcnt_q <= KW'(NW);
		end else if (!div_done) begin
			dcnt_q <= dcnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (div_load) begin
			dq_q <= div_num;
			dr_q <= '0;
			dd_q <= div_den;
		end else if (!div_done) begin
			if (!rem_sub[DW]) begin
				dr_q <= rem_sub;
				dq_q <= {dq_q[NW-2:0], 1'b1};
			end else begin
				dr_q <= rem_sh;
				dq_q <= {dq_q[NW-2:0], 1'b0};
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (out_load) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			vertex_index <= nv_q;
			pos_x_twice  <= px_q;
			pos_y_twice  <= py_q;
			height_mean  <= mean_q;
			tex_u        <= u_q;
			tex_v        <= dq_q[hcd_pkg::TEX_W-1:0];
			tri_valid    <= (cx_q + 1'b1 < n_q) && (cy_q + 1'b1 < n_q);
			if ((cx_q + 1'b1 < n_q) && (cy_q + 1'b1 < n_q)) begin
				idx_below    <= nv_q + hcd_pkg::IDX_W'(n_q);
				idx_right    <= nv_q + 1'b1;
				idx_diagonal <= nv_q + hcd_pkg::IDX_W'(n_q) + 1'b1;
			end else begin
				idx_below    <= '0;
				idx_right    <= '0;
				idx_diagonal <= '0;
			end
			last_vertex  <= (cx_q + 1'b1 == n_q) && (cy_q + 1'b1 == n_q);
		end
	end

endmodule
